// ===== rtl/dmv_pkg.sv =====
`default_nettype none

package dmv_pkg;

	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_MAX_COLUMNS = 16;

	localparam int DATA_W = 32;
	localparam int CNT_W = 5;
	localparam int IDX_W = 4;
	localparam int ACC_W = 64;

	typedef enum logic [2:0] {
		ACT_WRITE   = 3'd0,
		ACT_ACCUM   = 3'd1,
		ACT_LOAD    = 3'd2,
		ACT_MUL     = 3'd3,
		ACT_MUL_T   = 3'd4,
		ACT_CLEAR   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_LENGTH  = 2'd1,
		ERR_RANGE   = 2'd2
	} error_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] index;
	} mac_ctl_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
	} mac_res_t;

	// clamp a 64-bit two's complement sum to the q16.16 range
	function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] s);
		logic [DATA_W-1:0] r;
		if (s[ACC_W-1] && (s[ACC_W-2:DATA_W-1] != {(ACC_W-DATA_W){1'b1}})) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else if (!s[ACC_W-1] && (s[ACC_W-2:DATA_W-1] != '0)) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = s[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dense_matrix_vector_multiply_core.sv =====
// Dense matrix-vector multiply on signed q16.16 data. The matrix (MAX_ROWS x MAX_COLUMNS
// entries, row-major) and the vector buffer live in single-port-write RAMs with a registered
// read. An accumulate reads the entry, and the update is written back the next cycle with
// forwarding for back-to-back hits on the same entry. A multiply walks the matrix through the
// one matrix read port with one multiply-accumulate per cycle; each product element goes
// through the n_in reads, the multiplier and accumulator stages and the hand-off into the
// output register, where n_in is the column count for y = Ax and the row count for y = A^T x;
// a product with no input terms gives one zero element per cycle while the output is free.
// No new transfer is taken while a product streams out. After reset and after every clear
// request a sweep zeroes all MAX_ROWS * MAX_COLUMNS matrix entries (256 at the defaults),
// during which the stream input stalls while configuration writes still go through.
`default_nettype none

module dense_matrix_vector_multiply_core #(
	parameter int MAX_ROWS = dmv_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = dmv_pkg::DEF_MAX_COLUMNS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row_index [3:0], column_index [7:4], operand_value [39:8]
	input  wire logic [39:0] s_tdata,
	// action [2:0]
	input  wire logic [2:0]  s_tuser,

	output logic             m_tvalid,
	input  wire logic        m_tready,
	// element_index [3:0], element_value [35:4], zero [39:36]
	output logic [39:0]      m_tdata,
	// error_code [1:0]
	output logic [1:0]       m_tuser,
	output logic             m_tlast,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int DW = dmv_pkg::DATA_W;
	localparam int CW = dmv_pkg::CNT_W;
	localparam int IW = dmv_pkg::IDX_W;
	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
	localparam int VEC_AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
	localparam int LEN_W = $clog2(VEC_DEPTH + 1);

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ISSUE,
		ST_DRAIN,
		ST_ZERO
	} state_t;

	state_t                state_q;

	logic [CW-1:0]         row_cnt_q;
	logic [CW-1:0]         col_cnt_q;
	logic                  cfg_wr;

	dmv_pkg::action_t      act;
	logic [IW-1:0]         row_idx;
	logic [IW-1:0]         col_idx;
	logic [DW-1:0]         opnd;
	logic                  accept;

	logic [CW-1:0]         rows_used;
	logic [CW-1:0]         cols_used;
	logic [CW-1:0]         n_in_live;
	logic [CW-1:0]         n_out_live;
	logic                  in_range;
	logic [MAT_AW-1:0]     ent_addr;
	logic                  out_free;

	logic [CW-1:0]         i_q;
	logic [CW-1:0]         j_q;
	logic [CW-1:0]         n_in_q;
	logic [CW-1:0]         n_out_q;
	logic                  trans_q;
	logic [MAT_AW-1:0]     clr_addr_q;
	logic [LEN_W-1:0]      vec_len_q;

	logic                  out_valid_q;
	logic [IW-1:0]         out_idx_q;
	logic [DW-1:0]         out_val_q;
	logic                  out_last_q;
	dmv_pkg::error_t       out_err_q;

	logic                  upd_valid_s1;
	logic                  upd_acc_s1;
	logic [MAT_AW-1:0]     upd_addr_s1;
	logic [DW-1:0]         upd_val_s1;
	logic                  fwd_valid_q;
	logic [MAT_AW-1:0]     fwd_addr_q;
	logic [DW-1:0]         fwd_data_q;
	logic [DW-1:0]         upd_old;
	logic [DW-1:0]         upd_new;

	logic [MAT_AW-1:0]     mul_addr;
	logic                  mat_we;
	logic [MAT_AW-1:0]     mat_waddr;
	logic [DW-1:0]         mat_wdata;
	logic [MAT_AW-1:0]     mat_raddr;
	logic [DW-1:0]         mat_rdata;
	logic                  vec_we;
	logic [DW-1:0]         vec_rdata;

	dmv_pkg::mac_ctl_t     ctl_s1;
	dmv_pkg::mac_res_t     mac_res;
	logic                  mac_busy;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROW_COUNT) begin
				row_cnt_q <= pwdata[CW-1:0];
			end else begin
				col_cnt_q <= pwdata[CW-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_COLUMN_COUNT) ? {{(32-CW){1'b0}}, col_cnt_q}
						       : {{(32-CW){1'b0}}, row_cnt_q};

	// input decode
	assign act     = dmv_pkg::action_t'(s_tuser[2:0]);
	assign row_idx = s_tdata[3:0];
	assign col_idx = s_tdata[7:4];
	assign opnd    = s_tdata[39:8];

	assign rows_used  = (int'(row_cnt_q) > MAX_ROWS) ? CW'(MAX_ROWS) : row_cnt_q;
	assign cols_used  = (int'(col_cnt_q) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : col_cnt_q;
	assign n_in_live  = (act == dmv_pkg::ACT_MUL_T) ? rows_used : cols_used;
	assign n_out_live = (act == dmv_pkg::ACT_MUL_T) ? cols_used : rows_used;
	assign in_range   = (int'(row_idx) < int'(rows_used)) && (int'(col_idx) < int'(cols_used));
	assign ent_addr   = MAT_AW'(int'(row_idx) * MAX_COLUMNS + int'(col_idx));

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_in_q      <= '0;
			n_out_q     <= '0;
			trans_q     <= 1'b0;
			vec_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mac_res.valid) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= mac_res.index;
				out_val_q   <= mac_res.value;
				out_last_q  <= (i_q == n_out_q - 1'b1);
				out_err_q   <= dmv_pkg::ERR_OK;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (act)
							dmv_pkg::ACT_WRITE, dmv_pkg::ACT_ACCUM: begin
								if (!in_range) begin
									out_valid_q <= 1'b1;
									out_idx_q   <= '0;
									out_val_q   <= '0;
									out_last_q  <= 1'b1;
									out_err_q   <= dmv_pkg::ERR_RANGE;
								end
							end
							dmv_pkg::ACT_LOAD: begin
								if (int'(vec_len_q) >= VEC_DEPTH) begin
									out_valid_q <= 1'b1;
									out_idx_q   <= '0;
									out_val_q   <= '0;
									out_last_q  <= 1'b1;
									out_err_q   <= dmv_pkg::ERR_RANGE;
								end else begin
									vec_len_q <= vec_len_q + 1'b1;
								end
							end
							dmv_pkg::ACT_MUL, dmv_pkg::ACT_MUL_T: begin
								vec_len_q <= '0;
								trans_q   <= (act == dmv_pkg::ACT_MUL_T);
								n_in_q    <= n_in_live;
								n_out_q   <= n_out_live;
								i_q       <= '0;
								j_q       <= '0;
								if (int'(vec_len_q) != int'(n_in_live)) begin
									out_valid_q <= 1'b1;
									out_idx_q   <= '0;
									out_val_q   <= '0;
									out_last_q  <= 1'b1;
									out_err_q   <= dmv_pkg::ERR_LENGTH;
								end else if (n_out_live != '0) begin
									state_q <= (n_in_live == '0) ? ST_ZERO : ST_ISSUE;
								end
							end
							dmv_pkg::ACT_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == MAT_AW'(MAT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					if (j_q == n_in_q - 1'b1) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.valid && !mac_busy && out_free) begin
						if (i_q == n_out_q - 1'b1) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ZERO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= i_q[IW-1:0];
						out_val_q   <= '0;
						out_last_q  <= (i_q == n_out_q - 1'b1);
						out_err_q   <= dmv_pkg::ERR_OK;
						if (i_q == n_out_q - 1'b1) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_val_q, out_idx_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

	// entry update stage, written back in the cycle after the read, and the MAC control stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_valid_s1 <= 1'b0;
			fwd_valid_q  <= 1'b0;
			ctl_s1       <= '0;
		end else begin
			upd_valid_s1 <= accept && in_range
					&& ((act == dmv_pkg::ACT_WRITE) || (act == dmv_pkg::ACT_ACCUM));
			fwd_valid_q  <= upd_valid_s1;
			ctl_s1.valid <= (state_q == ST_ISSUE);
			ctl_s1.first <= (j_q == '0);
			ctl_s1.last  <= (j_q == n_in_q - 1'b1);
			ctl_s1.index <= i_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		upd_acc_s1  <= (act == dmv_pkg::ACT_ACCUM);
		upd_addr_s1 <= ent_addr;
		upd_val_s1  <= opnd;
		fwd_addr_q  <= upd_addr_s1;
		fwd_data_q  <= upd_new;
	end

	// the read missed a write that landed at the same edge
	assign upd_old = (fwd_valid_q && (fwd_addr_q == upd_addr_s1)) ? fwd_data_q : mat_rdata;
	assign upd_new = upd_acc_s1
		? dmv_pkg::sat32({{(dmv_pkg::ACC_W-DW){upd_old[DW-1]}}, upd_old}
				 + {{(dmv_pkg::ACC_W-DW){upd_val_s1[DW-1]}}, upd_val_s1})
		: upd_val_s1;

	// memory ports
	assign mul_addr = trans_q ? MAT_AW'(int'(j_q) * MAX_COLUMNS + int'(i_q))
				  : MAT_AW'(int'(i_q) * MAX_COLUMNS + int'(j_q));

	assign mat_raddr = (state_q == ST_ISSUE) ? mul_addr : ent_addr;

	always_comb begin
		mat_we    = 1'b0;
		mat_waddr = upd_addr_s1;
		mat_wdata = upd_new;
		priority if (state_q == ST_CLEAR) begin
			mat_we    = 1'b1;
			mat_waddr = clr_addr_q;
			mat_wdata = '0;
		end else if (upd_valid_s1) begin
			mat_we = 1'b1;
		end
	end

	assign vec_we = accept && (act == dmv_pkg::ACT_LOAD) && (int'(vec_len_q) < VEC_DEPTH);

	dmv_ram #(
		.WIDTH  (DW),
		.DEPTH  (MAT_DEPTH),
		.ADDR_W (MAT_AW)
	) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	dmv_ram #(
		.WIDTH  (DW),
		.DEPTH  (VEC_DEPTH),
		.ADDR_W (VEC_AW)
	) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (VEC_AW'(vec_len_q)),
		.wdata (opnd),
		.raddr (VEC_AW'(j_q)),
		.rdata (vec_rdata)
	);

	dmv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.a_data (mat_rdata),
		.x_data (vec_rdata),
		.res    (mac_res),
		.busy   (mac_busy)
	);

	// a finished element never lands on a result still waiting
	a_mac_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.valid |-> (!out_valid_q || m_tready))
		else $error("product element overwrites a pending result");

	// no transfer is taken while the multiply pipeline holds work
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!ctl_s1.valid && !mac_busy))
		else $error("input transfer taken during a product");

	// the clear sweep and an entry update never share the write port
	a_wport_excl: assert property (@(posedge clk) disable iff (!arst_n)
		upd_valid_s1 |-> (state_q != ST_CLEAR))
		else $error("entry update collides with clear sweep");

	// loaded vector never grows past the buffer
	a_vec_len: assert property (@(posedge clk) disable iff (!arst_n)
		int'(vec_len_q) <= VEC_DEPTH)
		else $error("vector length past buffer depth");

endmodule

`default_nettype wire

// ===== rtl/dmv_ram.sv =====
`default_nettype none

module dmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and a write to the same entry return the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/dmv_mac.sv =====
`default_nettype none

module dmv_mac (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dmv_pkg::mac_ctl_t               ctl_s1,
	input  wire logic [dmv_pkg::DATA_W-1:0]      a_data,
	input  wire logic [dmv_pkg::DATA_W-1:0]      x_data,
	output dmv_pkg::mac_res_t                    res,
	output logic                                 busy
);

	dmv_pkg::mac_ctl_t                 ctl_s2;
	logic signed [dmv_pkg::ACC_W-1:0]  prod_s2;
	logic [dmv_pkg::ACC_W-1:0]         acc_q;
	logic [dmv_pkg::ACC_W-1:0]         sum_next;
	logic signed [dmv_pkg::ACC_W-1:0]  prod_shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= dmv_pkg::ACC_W'(signed'(a_data) * signed'(x_data));
	end

	// floor shift back to q16.16 before summing
	assign prod_shr = prod_s2 >>> 16;
	assign sum_next = (ctl_s2.first ? '0 : acc_q) + dmv_pkg::ACC_W'(prod_shr);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= sum_next;
		end
	end

	always_comb begin
		res.valid = ctl_s2.valid && ctl_s2.last;
		res.last  = 1'b0;
		res.index = ctl_s2.index;
		res.value = dmv_pkg::sat32(sum_next);
	end

	assign busy = ctl_s2.valid;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VEC_DEPTH = (dmv_pkg::DEF_MAX_ROWS > dmv_pkg::DEF_MAX_COLUMNS)
		? dmv_pkg::DEF_MAX_ROWS : dmv_pkg::DEF_MAX_COLUMNS;
	localparam int REG_ROW_COUNT = 0;
	localparam int REG_COLUMN_COUNT = 1;
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 430;
	localparam int SETTLE_CYCLES = 300;
	localparam int PLAN_LEN = 31;

	typedef struct packed {
		logic [dmv_pkg::IDX_W-1:0]  index;
		logic [dmv_pkg::DATA_W-1:0] value;
		logic                       last;
		dmv_pkg::error_t            err;
	} product_t;

	typedef enum {STEP_CFG, STEP_MODEL, STEP_NONE, STEP_ONE} step_kind_t;

	typedef struct {
		step_kind_t      kind;
		logic [2:0]      act;
		logic [3:0]      r;
		logic [3:0]      c;
		logic [31:0]     v;
		int              rep;
		dmv_pkg::error_t err;
		logic [31:0]     value;
	} plan_step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dense_matrix_vector_multiply_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [31:0] matrix_q [dmv_pkg::DEF_MAX_ROWS*dmv_pkg::DEF_MAX_COLUMNS];
	logic [31:0] vector_q [VEC_DEPTH];
	int          vector_fill;
	logic [4:0]  row_count_q;
	logic [4:0]  column_count_q;
	product_t    fresh_products [VEC_DEPTH];
	product_t    pending_products [$];
	int          items_sent;
	int          mismatches;
	int          sender_idle;
	int          receiver_idle;

	plan_step_t plan [PLAN_LEN] = '{
		'{STEP_NONE, dmv_pkg::ACT_MUL, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_WRITE, 4'd0, 4'd0, 32'h0001_0000, 1, dmv_pkg::ERR_RANGE, 32'h0},
		'{STEP_MODEL, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h0002_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL_T, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_LENGTH, 32'h0},
		'{STEP_CFG, dmv_pkg::ACT_WRITE, 4'(REG_ROW_COUNT), 4'd0, 32'd1, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_CFG, dmv_pkg::ACT_WRITE, 4'(REG_COLUMN_COUNT), 4'd0, 32'd1, 1, dmv_pkg::ERR_OK,
			32'h0},
		'{STEP_NONE, dmv_pkg::ACT_WRITE, 4'd0, 4'd0, 32'h7fff_ffff, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_ACCUM, 4'd0, 4'd0, 32'h7fff_ffff, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h0001_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK,
			32'h7fff_ffff},
		'{STEP_NONE, dmv_pkg::ACT_ACCUM, 4'd0, 4'd0, 32'h8000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_ACCUM, 4'd0, 4'd0, 32'h8000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h0001_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL_T, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK,
			32'h8000_0000},
		'{STEP_ONE, dmv_pkg::ACT_WRITE, 4'd1, 4'd0, 32'h0001_0000, 1, dmv_pkg::ERR_RANGE, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_ACCUM, 4'd0, 4'd15, 32'h0001_0000, 1, dmv_pkg::ERR_RANGE, 32'h0},
		'{STEP_NONE, ACT_SPARE_A, 4'd15, 4'd15, 32'hffff_ffff, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, ACT_SPARE_B, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_MODEL, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h0003_8000, 2, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_LENGTH, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_CLEAR, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h7fff_ffff, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_CFG, dmv_pkg::ACT_WRITE, 4'(REG_ROW_COUNT), 4'd0, 32'd16, 1, dmv_pkg::ERR_OK,
			32'h0},
		'{STEP_CFG, dmv_pkg::ACT_WRITE, 4'(REG_COLUMN_COUNT), 4'd0, 32'd16, 1, dmv_pkg::ERR_OK,
			32'h0},
		'{STEP_MODEL, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h8000_0000, 16, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h8000_0000, 1, dmv_pkg::ERR_RANGE, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_WRITE, 4'd15, 4'd15, 32'h8000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_NONE, dmv_pkg::ACT_WRITE, 4'd0, 4'd0, 32'h7fff_ffff, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_MODEL, dmv_pkg::ACT_MUL, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_OK, 32'h0},
		'{STEP_ONE, dmv_pkg::ACT_MUL_T, 4'd0, 4'd0, 32'h0000_0000, 1, dmv_pkg::ERR_LENGTH, 32'h0}
	};

	function automatic int dim_used(logic [4:0] raw, int cap);
		return (raw > cap) ? cap : int'(raw);
	endfunction

	function automatic logic [31:0] clamp_q16(logic signed [63:0] s);
		if (s > 64'sh0000_0000_7fff_ffff)
			return 32'h7fff_ffff;
		if (s < -64'sh0000_0000_8000_0000)
			return 32'h8000_0000;
		return s[31:0];
	endfunction

	// updates the shadow matrix and vector, fills fresh_products, returns the count
	function automatic int apply_action(logic [2:0] act, logic [3:0] r, logic [3:0] c,
			logic [31:0] v);
		int nr;
		int nc;
		int n_out;
		int n_in;
		int len;
		int idx;
		logic signed [63:0] lhs;
		logic signed [63:0] rhs;
		logic signed [63:0] sum;
		nr = dim_used(row_count_q, dmv_pkg::DEF_MAX_ROWS);
		nc = dim_used(column_count_q, dmv_pkg::DEF_MAX_COLUMNS);
		case (act)
			dmv_pkg::ACT_WRITE, dmv_pkg::ACT_ACCUM: begin
				if (r >= nr || c >= nc) begin
					fresh_products[0] = '{4'd0, 32'd0, 1'b1, dmv_pkg::ERR_RANGE};
					return 1;
				end
				idx = r * dmv_pkg::DEF_MAX_COLUMNS + c;
				if (act == dmv_pkg::ACT_WRITE) begin
					matrix_q[idx] = v;
				end else begin
					lhs = $signed(matrix_q[idx]);
					rhs = $signed(v);
					matrix_q[idx] = clamp_q16(lhs + rhs);
				end
				return 0;
			end
			dmv_pkg::ACT_LOAD: begin
				if (vector_fill >= VEC_DEPTH) begin
					fresh_products[0] = '{4'd0, 32'd0, 1'b1, dmv_pkg::ERR_RANGE};
					return 1;
				end
				vector_q[vector_fill] = v;
				vector_fill++;
				return 0;
			end
			dmv_pkg::ACT_MUL, dmv_pkg::ACT_MUL_T: begin
				n_out = (act == dmv_pkg::ACT_MUL_T) ? nc : nr;
				n_in = (act == dmv_pkg::ACT_MUL_T) ? nr : nc;
				len = vector_fill;
				vector_fill = 0;
				if (len != n_in) begin
					fresh_products[0] = '{4'd0, 32'd0, 1'b1, dmv_pkg::ERR_LENGTH};
					return 1;
				end
				for (int i = 0; i < n_out; i++) begin
					sum = 0;
					for (int j = 0; j < n_in; j++) begin
						idx = (act == dmv_pkg::ACT_MUL_T) ? (j * dmv_pkg::DEF_MAX_COLUMNS + i)
							: (i * dmv_pkg::DEF_MAX_COLUMNS + j);
						lhs = $signed(matrix_q[idx]);
						rhs = $signed(vector_q[j]);
						sum = sum + ((lhs * rhs) >>> 16);
					end
					fresh_products[i] = '{4'(i), clamp_q16(sum), (i == n_out - 1),
						dmv_pkg::ERR_OK};
				end
				return n_out;
			end
			dmv_pkg::ACT_CLEAR: begin
				foreach (matrix_q[k])
					matrix_q[k] = 32'd0;
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	task automatic push_item(logic [2:0] act, logic [3:0] r, logic [3:0] c, logic [31:0] v,
			step_kind_t kind, dmv_pkg::error_t err, logic [31:0] value);
		int produced;
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {v, c, r};
		do @(posedge clk); while (!s_tready);
		produced = apply_action(act, r, c, v);
		if (act <= dmv_pkg::ACT_CLEAR)
			items_sent++;
		case (kind)
			STEP_MODEL: begin
				for (int k = 0; k < produced; k++)
					pending_products.push_back(fresh_products[k]);
			end
			STEP_ONE: pending_products.push_back('{4'd0, value, 1'b1, err});
			default: ;
		endcase
	endtask

	// covers the clearing sweep, which yields no product
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(int reg_idx, logic [4:0] value);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(reg_idx * 4);
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_idx == REG_ROW_COUNT)
			row_count_q = value;
		else
			column_count_q = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [4:0] pick_dim();
		int k;
		k = $urandom_range(0, 9);
		if (k < 6)
			return 5'($urandom_range(1, 4));
		if (k == 6)
			return 5'd0;
		if (k == 7)
			return 5'd16;
		return 5'($urandom_range(5, 16));
	endfunction

	function automatic logic [31:0] random_operand();
		int k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return $urandom;
		if (k == 1) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0000;
			endcase
		end
		// small q16.16 values within +-8.0
		return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
	endfunction

	task automatic run_scene(bit reconfigure);
		int nr;
		int nc;
		int n_in;
		int len;
		bit trans;
		logic [2:0] act;
		if (reconfigure) begin
			set_register(REG_ROW_COUNT, pick_dim());
			set_register(REG_COLUMN_COUNT, pick_dim());
		end
		nr = dim_used(row_count_q, dmv_pkg::DEF_MAX_ROWS);
		nc = dim_used(column_count_q, dmv_pkg::DEF_MAX_COLUMNS);
		// noise: any action, any index
		repeat ($urandom_range(0, 2)) begin
			act = 3'($urandom_range(0, 7));
			if (act == dmv_pkg::ACT_CLEAR && $urandom_range(0, 5) != 0)
				act = dmv_pkg::ACT_ACCUM;
			push_item(act, 4'($urandom), 4'($urandom), random_operand(),
				STEP_MODEL, dmv_pkg::ERR_OK, 32'h0);
		end
		if (nr > 0 && nc > 0) begin
			repeat ($urandom_range(0, 8)) begin
				act = ($urandom_range(0, 3) != 0) ? dmv_pkg::ACT_WRITE : dmv_pkg::ACT_ACCUM;
				push_item(act, 4'($urandom_range(0, nr - 1)), 4'($urandom_range(0, nc - 1)),
					random_operand(), STEP_MODEL, dmv_pkg::ERR_OK, 32'h0);
			end
		end
		trans = 1'($urandom_range(0, 1));
		n_in = trans ? nr : nc;
		case ($urandom_range(0, 15))
			0: len = n_in + 1;
			1: len = (n_in > 0) ? n_in - 1 : 1;
			2: len = VEC_DEPTH + 1;
			default: len = n_in;
		endcase
		repeat (len)
			push_item(dmv_pkg::ACT_LOAD, 4'($urandom), 4'($urandom), random_operand(),
				STEP_MODEL, dmv_pkg::ERR_OK, 32'h0);
		push_item(trans ? dmv_pkg::ACT_MUL_T : dmv_pkg::ACT_MUL, 4'($urandom), 4'($urandom),
			$urandom, STEP_MODEL, dmv_pkg::ERR_OK, 32'h0);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= receiver_idle);

	always @(posedge clk) begin
		product_t seen;
		product_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = '{m_tdata[3:0], m_tdata[35:4], m_tlast, dmv_pkg::error_t'(m_tuser)};
			if (pending_products.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected product: index %0d value %h last %b error %0d",
						seen.index, seen.value, seen.last, seen.err);
				mismatches++;
			end else begin
				want = pending_products.pop_front();
				if (seen.index !== want.index || seen.value !== want.value
						|| seen.last !== want.last || seen.err !== want.err) begin
					if (mismatches < 10)
						$display({"product mismatch: expected index %0d value %h last %b",
							" error %0d, got index %0d value %h last %b error %0d"},
							want.index, want.value, want.last, want.err,
							seen.index, seen.value, seen.last, seen.err);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int start;
		bit first;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (matrix_q[k])
			matrix_q[k] = 32'd0;
		foreach (vector_q[k])
			vector_q[k] = 32'd0;
		vector_fill = 0;
		row_count_q = 5'd0;
		column_count_q = 5'd0;
		items_sent = 0;
		mismatches = 0;
		sender_idle = 29;
		receiver_idle = 70;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				set_register(int'(plan[i].r), plan[i].v[4:0]);
			end else begin
				repeat (plan[i].rep)
					push_item(plan[i].act, plan[i].r, plan[i].c, plan[i].v,
						plan[i].kind, plan[i].err, plan[i].value);
			end
		end

		start = items_sent;
		first = 1'b1;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start < RANDOM_ITEMS / 3) begin
				sender_idle = 29;
				receiver_idle = 70;
			end else if (items_sent - start < 2 * RANDOM_ITEMS / 3) begin
				sender_idle = 70;
				receiver_idle = 29;
			end else begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			run_scene(first || $urandom_range(0, 2) == 0);
			first = 1'b0;
		end

		wait_drained();
		if (mismatches == 0 && pending_products.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ===== dense_matrix_vector_multiply_core.f =====
rtl/dmv_pkg.sv
rtl/dmv_ram.sv
rtl/dmv_mac.sv
rtl/dense_matrix_vector_multiply_core.sv
dv/testbench.sv
